// ===== rtl/ldpc_pkg.sv =====
package ldpc_pkg;

   // Phase window edges and timer loads
   localparam logic [10:0] A_OFF_AT   = 11'd970;
   localparam logic [10:0] B_ON_AT    = 11'd1000;
   localparam logic [10:0] B_OFF_AT   = 11'd1970;
   localparam logic [6:0]  SHORT_BEEP = 7'd30;
   localparam logic [6:0]  LONG_BEEP  = 7'd100;
   localparam logic [5:0]  LED_BLINK  = 6'd50;
   localparam logic [1:0]  TOP_LEVEL  = 2'd3;

   // Key event codes
   localparam logic [1:0] KEY_NONE  = 2'd0;
   localparam logic [1:0] KEY_SHORT = 2'd1;
   localparam logic [1:0] KEY_LONG  = 2'd2;

   // Register indexes
   localparam int unsigned CsrIndexWidth = 3;
   localparam logic [CsrIndexWidth-1:0] CSR_DUTY_ONE   = 3'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_DUTY_TWO   = 3'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_DUTY_THREE = 3'd2;
   localparam logic [CsrIndexWidth-1:0] CSR_REMEMBER   = 3'd3;
   localparam logic [CsrIndexWidth-1:0] CSR_AUTO_OFF   = 3'd4;
   localparam logic [CsrIndexWidth-1:0] CSR_IDLE_SLEEP = 3'd5;
   localparam logic [CsrIndexWidth-1:0] CSR_LOW_BATT   = 3'd6;

   typedef struct packed {
      logic [1:0] key_event;
      logic       key_busy;
      logic       charging;
      logic       charge_done;
      logic       low_battery;
   } req_type;

   typedef struct packed {
      logic [1:0] level;
      logic [7:0] duty;
      logic       drive_a_on;
      logic       drive_b_on;
      logic       beep_on;
      logic       status_led;
      logic       charge_led_a;
      logic       charge_led_b;
      logic       sleep_request;
   } rsp_type;

   typedef struct packed {
      logic [7:0]  duty_level_one;
      logic [7:0]  duty_level_two;
      logic [7:0]  duty_level_three;
      logic [15:0] remember_ticks;
      logic [15:0] auto_off_ticks;
      logic [15:0] idle_sleep_ticks;
      logic [9:0]  low_battery_ticks;
   } cfg_type;

endpackage

// ===== rtl/ldpc_csr.sv =====
module ldpc_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [ldpc_pkg::CsrIndexWidth-1:0]  csr_index,
   input  logic [15:0]                         csr_data,
   output ldpc_pkg::cfg_type                   cfg
);

   ldpc_pkg::cfg_type cfg_ff, cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            ldpc_pkg::CSR_DUTY_ONE:   cfg_in.duty_level_one    = csr_data[7:0];
            ldpc_pkg::CSR_DUTY_TWO:   cfg_in.duty_level_two    = csr_data[7:0];
            ldpc_pkg::CSR_DUTY_THREE: cfg_in.duty_level_three  = csr_data[7:0];
            ldpc_pkg::CSR_REMEMBER:   cfg_in.remember_ticks    = csr_data;
            ldpc_pkg::CSR_AUTO_OFF:   cfg_in.auto_off_ticks    = csr_data;
            ldpc_pkg::CSR_IDLE_SLEEP: cfg_in.idle_sleep_ticks  = csr_data;
            ldpc_pkg::CSR_LOW_BATT:   cfg_in.low_battery_ticks = csr_data[9:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.duty_level_one    <= 8'd23;
         cfg_ff.duty_level_two    <= 8'd37;
         cfg_ff.duty_level_three  <= 8'd50;
         cfg_ff.remember_ticks    <= 16'd2000;
         cfg_ff.auto_off_ticks    <= 16'd12000;
         cfg_ff.idle_sleep_ticks  <= 16'd500;
         cfg_ff.low_battery_ticks <= 10'd500;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== rtl/ldpc_core.sv =====
module ldpc_core #(
   parameter int unsigned PHASE_PERIOD = 2000
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  ldpc_pkg::req_type req,
   input  ldpc_pkg::cfg_type cfg,
   output ldpc_pkg::rsp_type rsp
);

   localparam logic [10:0] PERIOD = 11'(PHASE_PERIOD);

   logic [1:0]  level_ff, level_in;
   logic        enabled_ff, enabled_in;
   logic [1:0]  remembered_ff, remembered_in;
   logic [15:0] hold_ff, hold_in;
   logic [10:0] phase_ff, phase_in;
   logic [6:0]  beep_ff, beep_in;
   logic        beep_active_ff, beep_active_in;
   logic [15:0] idle_ff, idle_in;
   logic [9:0]  low_batt_ff, low_batt_in;
   logic [5:0]  blink_ff, blink_in;
   logic        drive_a_ff, drive_a_in;
   logic        drive_b_ff, drive_b_in;
   logic        led_ff, led_in;
   logic        led_a, led_b, sleep;
   logic [11:0] phase_sum;
   logic [10:0] phase_step;

   always_comb begin
      level_in       = level_ff;
      enabled_in     = enabled_ff;
      remembered_in  = remembered_ff;
      hold_in        = hold_ff;
      phase_in       = phase_ff;
      beep_in        = beep_ff;
      beep_active_in = beep_active_ff;
      idle_in        = idle_ff;
      low_batt_in    = low_batt_ff;
      blink_in       = blink_ff;
      drive_a_in     = drive_a_ff;
      drive_b_in     = drive_b_ff;
      led_in         = led_ff;
      sleep          = 1'b0;
      led_a          = 1'b1;
      led_b          = 1'b1;
      phase_sum      = {1'b0, phase_ff} + 12'd1;
      phase_step     = phase_sum[10:0];

      // key handling, charger forces the drive off
      priority if (req.charging) begin
         level_in   = 2'd0;
         drive_a_in = 1'b0;
         drive_b_in = 1'b0;
      end else if (req.key_event == ldpc_pkg::KEY_SHORT && enabled_ff) begin
         beep_in       = ldpc_pkg::SHORT_BEEP;
         hold_in       = 16'd0;
         remembered_in = 2'd0;
         level_in      = (level_ff == ldpc_pkg::TOP_LEVEL) ? 2'd1 : level_ff + 2'd1;
      end else if (req.key_event == ldpc_pkg::KEY_LONG) begin
         hold_in = 16'd0;
         beep_in = ldpc_pkg::LONG_BEEP;
         if (level_ff != 2'd0) begin
            level_in   = 2'd0;
            enabled_in = 1'b0;
         end else begin
            enabled_in = 1'b1;
            level_in   = (remembered_ff != 2'd0) ? remembered_ff : 2'd1;
         end
      end else begin
      end

      // drive control
      if (level_in == 2'd0) begin
         drive_a_in = 1'b0;
         drive_b_in = 1'b0;
         hold_in    = 16'd0;
      end else begin
         phase_in = (phase_step >= PERIOD) ? 11'd0 : phase_step;
         priority if (phase_in < ldpc_pkg::A_OFF_AT) drive_a_in = 1'b1;
         else if (phase_in < ldpc_pkg::B_ON_AT)     drive_a_in = 1'b0;
         else if (phase_in < ldpc_pkg::B_OFF_AT)    drive_b_in = 1'b1;
         else                                       drive_b_in = 1'b0;
         if (hold_in != 16'hFFFF) hold_in = hold_in + 16'd1;
         if (hold_in > cfg.remember_ticks) remembered_in = level_in;
         if (hold_in > cfg.auto_off_ticks) begin
            level_in   = 2'd0;
            drive_a_in = 1'b0;
            drive_b_in = 1'b0;
         end
      end

      // status LED, blink uses the count before this tick's increment
      if (req.low_battery) begin
         if (blink_ff == 6'd0) led_in = ~led_ff;
      end else begin
         led_in = (level_in == 2'd0);
      end

      // charge LEDs and idle sleep
      if (req.charging) begin
         led_a = ~req.charge_done;
         led_b = req.charge_done;
      end else if (level_in == 2'd0) begin
         idle_in = idle_ff + 16'd1;
         if (idle_in == cfg.idle_sleep_ticks && !req.key_busy) begin
            idle_in = 16'd0;
            sleep   = 1'b1;
         end
      end else begin
         idle_in = 16'd0;
      end

      // beeper
      if (beep_in != 7'd0) begin
         beep_in        = beep_in - 7'd1;
         beep_active_in = 1'b1;
      end else begin
         beep_active_in = 1'b0;
      end

      // low battery; the count stays below its limit, so blink tracks it mod 50
      if (req.low_battery) begin
         low_batt_in = low_batt_ff + 10'd1;
         blink_in    = (blink_ff == ldpc_pkg::LED_BLINK - 6'd1) ? 6'd0 : blink_ff + 6'd1;
         if (low_batt_in >= cfg.low_battery_ticks) begin
            low_batt_in = 10'd0;
            blink_in    = 6'd0;
            level_in    = 2'd0;
            drive_a_in  = 1'b0;
            drive_b_in  = 1'b0;
            idle_in     = 16'd0;
            sleep       = 1'b1;
         end
      end else begin
         low_batt_in = 10'd0;
         blink_in    = 6'd0;
      end

      rsp.level = level_in;
      unique case (level_in)
         2'd1:    rsp.duty = cfg.duty_level_one;
         2'd2:    rsp.duty = cfg.duty_level_two;
         2'd3:    rsp.duty = cfg.duty_level_three;
         default: rsp.duty = 8'd0;
      endcase
      rsp.drive_a_on    = drive_a_in;
      rsp.drive_b_on    = drive_b_in;
      rsp.beep_on       = beep_active_in;
      rsp.status_led    = led_in;
      rsp.charge_led_a  = led_a;
      rsp.charge_led_b  = led_b;
      rsp.sleep_request = sleep;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff       <= 2'd0;
         enabled_ff     <= 1'b0;
         remembered_ff  <= 2'd0;
         hold_ff        <= 16'd0;
         phase_ff       <= 11'd0;
         beep_ff        <= 7'd0;
         beep_active_ff <= 1'b0;
         idle_ff        <= 16'd0;
         low_batt_ff    <= 10'd0;
         blink_ff       <= 6'd0;
         drive_a_ff     <= 1'b0;
         drive_b_ff     <= 1'b0;
         led_ff         <= 1'b0;
      end else if (advance) begin
         level_ff       <= level_in;
         enabled_ff     <= enabled_in;
         remembered_ff  <= remembered_in;
         hold_ff        <= hold_in;
         phase_ff       <= phase_in;
         beep_ff        <= beep_in;
         beep_active_ff <= beep_active_in;
         idle_ff        <= idle_in;
         low_batt_ff    <= low_batt_in;
         blink_ff       <= blink_in;
         drive_a_ff     <= drive_a_in;
         drive_b_ff     <= drive_b_in;
         led_ff         <= led_in;
      end
   end

endmodule

// ===== rtl/level_drive_power_controller.sv =====
// Level drive power controller. Each req_ transaction is one 10 ms tick with
// the key event and charger/battery flags; each tick yields exactly one rsp_
// transaction carrying the drive level, its duty value, the two alternating
// drive enables, beeper, status LED, charge LEDs and a sleep request pulse.
// A tick is captured in an input register and resolved in a single pass of
// logic into the result register: one tick per clock sustained while
// rsp_ready is high; rsp_valid rises as the tick enters the result register.
// An untaken full result holds the input register; req_ready drops while it
// is held. Registers are written over the csr_ port (index 0..6: three duty
// values, remember, auto-off, idle-sleep and low-battery tick limits), which
// is always ready; write them only while no tick is in flight.
module level_drive_power_controller #(
   parameter int unsigned PHASE_PERIOD = 2000
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  ldpc_pkg::req_type                   req_payload,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output ldpc_pkg::rsp_type                   rsp_payload,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [ldpc_pkg::CsrIndexWidth-1:0]  csr_index,
   input  logic [15:0]                         csr_data
);

   ldpc_pkg::cfg_type cfg;
   ldpc_pkg::req_type req_ff;
   ldpc_pkg::rsp_type rsp_ff, rsp_in;
   logic              in_valid_ff;
   logic              out_valid_ff;
   logic              advance;

   // move the held tick into the result register when that slot is free or its result is being taken
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = rsp_ff;

   ldpc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   ldpc_core #(
      .PHASE_PERIOD (PHASE_PERIOD)
   ) u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .req     (req_ff),
      .cfg     (cfg),
      .rsp     (rsp_in)
   );

   // control: input and result occupancy
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_ready) in_valid_ff <= req_valid;
         if (advance) out_valid_ff <= 1'b1;
         else if (rsp_ready) out_valid_ff <= 1'b0;
      end
   end

   // payload: capture the tick, hold the result until taken
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) req_ff <= req_payload;
      if (advance) rsp_ff <= rsp_in;
   end

endmodule
